FILE: hw/rtl/highpass_level_meter_silence_detect_defines.svh
// Assertion macros for the top-level file, which checks its own logic.
`ifndef HIGHPASS_LEVEL_METER_SILENCE_DETECT_DEFINES_SVH
`define HIGHPASS_LEVEL_METER_SILENCE_DETECT_DEFINES_SVH

// Condition and consequence in the same cycle.
`define HLM_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Consequence in the cycle after the condition.
`define HLM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: hw/rtl/hlm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hlm_pkg;

	// Framing of the level meter.
	localparam int FRAME_SAMPLES     = 480;
	localparam int METER_STRIDE      = 8;
	localparam int FRAMES_PER_UPDATE = 2;

	localparam int POS_W    = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
	localparam int STRIDE_W = (METER_STRIDE > 1) ? $clog2(METER_STRIDE) : 1;
	localparam int PARITY_W = (FRAMES_PER_UPDATE > 1) ? $clog2(FRAMES_PER_UPDATE) : 1;

	localparam logic [POS_W-1:0]    FRAME_LAST  = POS_W'(FRAME_SAMPLES - 1);
	localparam logic [STRIDE_W-1:0] STRIDE_LAST = STRIDE_W'(METER_STRIDE - 1);
	localparam logic [PARITY_W-1:0] PARITY_LAST = PARITY_W'(FRAMES_PER_UPDATE - 1);

	// Number of squared samples per interval, never zero.
	localparam int METER_DIV = (FRAME_SAMPLES / METER_STRIDE == 0) ? 1 :
		FRAME_SAMPLES / METER_STRIDE;

	// Filter datapath.
	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 15;
	localparam int Y_W       = 22;
	localparam int DIFF_W    = 24;
	localparam int PROD_W    = DIFF_W + COEF_W + 1;
	localparam int FRAC_BITS = 15;

	localparam logic signed [PROD_W-1:0] Y_MAX_P = PROD_W'(2 ** (Y_W - 1) - 1);
	localparam logic signed [PROD_W-1:0] Y_MIN_P = PROD_W'(-(2 ** (Y_W - 1)));
	localparam logic signed [Y_W-1:0]    Y_MAX_Y = Y_W'(2 ** (Y_W - 1) - 1);
	localparam logic signed [Y_W-1:0]    Y_MIN_Y = Y_W'(-(2 ** (Y_W - 1)));
	localparam logic signed [Y_W-1:0]    S_MAX_Y = Y_W'(2 ** (SAMPLE_W - 1) - 1);
	localparam logic signed [Y_W-1:0]    S_MIN_Y = Y_W'(-(2 ** (SAMPLE_W - 1)));

	// Energy, division and square root.
	localparam int ENERGY_W     = 28;
	localparam int ENERGY_SHIFT = 4;
	localparam int V_W          = SAMPLE_W - ENERGY_SHIFT;
	localparam int SQ_W         = 2 * V_W;
	localparam int ROOT_W       = ENERGY_W / 2;
	localparam int SQ_REM_W     = ROOT_W + 3;
	localparam int STEP_W       = $clog2(ENERGY_W + 1);

	localparam logic [STEP_W-1:0] ROOT_STEP_LAST = STEP_W'(ROOT_W - 1);

	// Division by the interval count as a reciprocal product, exact over the
	// whole energy range: the multiplier is the rounded-up reciprocal.
	localparam int     DIV_SHIFT   = ENERGY_W + $clog2(METER_DIV);
	localparam int     DIV_RECIP_W = ENERGY_W + 1;
	localparam int     DIV_PROD_W  = ENERGY_W + DIV_RECIP_W;
	localparam longint DIV_RECIP   = ((longint'(1) <<< DIV_SHIFT) + METER_DIV - 1) / METER_DIV;
	localparam logic [DIV_RECIP_W-1:0] DIV_RECIP_V = DIV_RECIP_W'(DIV_RECIP);

	// Level scaling: 16/40 is 2/5; division by five by reciprocal.
	localparam int DIV5_MUL_W    = 16;
	localparam int DIV5_MUL      = 52429;
	localparam int DIV5_SHIFT    = 18;
	localparam int SCALED_W      = ROOT_W + 1;
	localparam int SCALE_PROD_W  = SCALED_W + DIV5_MUL_W;
	localparam int SCALE_Q_W     = SCALE_PROD_W - DIV5_SHIFT;

	localparam int LEVEL_W   = 7;
	localparam int LEVEL_MAX = 100;
	localparam int QUIET_W   = 8;

	// Queue between the filter and the meter.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UPDATES = 2'd2;

	localparam logic [COEF_W-1:0]  COEF_RESET    = COEF_W'(31610);
	localparam logic [LEVEL_W-1:0] THRESH_RESET  = LEVEL_W'(10);
	localparam logic [QUIET_W-1:0] UPDATES_RESET = QUIET_W'(50);

	localparam int OUT_TDATA_W = 32;
	localparam int TDATA_PAD   = OUT_TDATA_W - SAMPLE_W - 2 * LEVEL_W;

	typedef struct packed {
		logic                       start;
		logic signed [SAMPLE_W-1:0] ys;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic                       silence_stop;
		logic                       level_update;
		logic [LEVEL_W-1:0]         smoothed_level;
		logic [LEVEL_W-1:0]         raw_level;
		logic signed [SAMPLE_W-1:0] filtered_sample;
	} result_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ACCUM,
		B_DIVIDE,
		B_ROOT,
		B_SCALE,
		B_METER,
		B_EMIT
	} back_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hlm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module hlm_queue import hlm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  push_data,
	input  logic      pop,
	output q_entry_t  head,
	output q_status_t q_stat
);

	q_entry_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Status and head of the queue.
	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/hlm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hlm_front import hlm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] in_sample,
	input  logic                       in_start,
	input  logic [COEF_W-1:0]          coef,
	input  q_status_t                  q_stat,
	output logic                       push,
	output q_entry_t                   push_data
);

	logic                       s1_valid_q;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic                       start_s1;
	logic signed [DIFF_W-1:0]   d_s1;

	logic signed [SAMPLE_W-1:0] xprev_q;
	logic signed [Y_W-1:0]      yprev_q;

	logic signed [SAMPLE_W-1:0] xprev_eff;
	logic signed [Y_W-1:0]      yprev_eff;
	logic signed [DIFF_W-1:0]   diff;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   y_full;
	logic signed [Y_W-1:0]      y_sat;
	logic signed [Y_W-1:0]      y_clip;
	logic                       accept;

	// One sample in flight: the next one waits for the filter feedback.
	assign in_ready = !s1_valid_q;
	assign accept   = in_valid && in_ready;

	// Stage one: difference term, with the filter cleared at a new take.
	always_comb begin
		xprev_eff = in_start ? '0 : xprev_q;
		yprev_eff = in_start ? '0 : yprev_q;
		diff = DIFF_W'(yprev_eff) + DIFF_W'(in_sample) - DIFF_W'(xprev_eff);
	end

	// Stage two: coefficient product, floor shift and both clamps.
	always_comb begin
		prod   = PROD_W'(d_s1) * PROD_W'($signed({1'b0, coef}));
		y_full = prod >>> FRAC_BITS;
		if (y_full > Y_MAX_P) begin
			y_sat = Y_MAX_Y;
		end else if (y_full < Y_MIN_P) begin
			y_sat = Y_MIN_Y;
		end else begin
			y_sat = y_full[Y_W-1:0];
		end
		if (y_sat > S_MAX_Y) begin
			y_clip = S_MAX_Y;
		end else if (y_sat < S_MIN_Y) begin
			y_clip = S_MIN_Y;
		end else begin
			y_clip = y_sat;
		end
	end

	assign push           = s1_valid_q && !q_stat.full;
	assign push_data.ys    = y_clip[SAMPLE_W-1:0];
	assign push_data.start = start_s1;

	// Control and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			xprev_q    <= '0;
			yprev_q    <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (push) begin
				s1_valid_q <= 1'b0;
				xprev_q    <= x_s1;
				yprev_q    <= y_sat;
			end
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1     <= in_sample;
			start_s1 <= in_start;
			d_s1     <= diff;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/hlm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hlm_back import hlm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  q_status_t          q_stat,
	input  q_entry_t           head,
	output logic               pop,
	input  logic [LEVEL_W-1:0] thresh,
	input  logic [QUIET_W-1:0] sil_upd,
	output logic               out_valid,
	input  logic               out_ready,
	output result_t            out_data
);

	back_state_t state_q, state_d;

	// Current sample and its registered square.
	logic signed [SAMPLE_W-1:0] ys_q;
	logic                       start_q;
	logic [SQ_W-1:0]            sq_q;

	// Meter state.
	logic [POS_W-1:0]    pos_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [PARITY_W-1:0] parity_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [LEVEL_W-1:0]  meter_q;
	logic [QUIET_W-1:0]  quiet_q;

	// Division, root and level working registers.
	logic [ENERGY_W-1:0]  dq_q;
	logic [ROOT_W-1:0]    root_q;
	logic [SQ_REM_W-1:0]  srem_q;
	logic [STEP_W-1:0]    step_q;
	logic [LEVEL_W-1:0]   raw_q;
	logic                 upd_q;

	logic    out_valid_q;
	result_t out_q;

	logic signed [V_W-1:0]  head_v;
	logic signed [SQ_W-1:0] head_sq;

	logic [POS_W-1:0]    eff_pos, pos_next;
	logic [STRIDE_W-1:0] eff_stride, stride_next;
	logic [PARITY_W-1:0] eff_parity, parity_next;
	logic [ENERGY_W-1:0] eff_energy, acc_val;
	logic [ENERGY_W:0]   acc_sum;
	logic [LEVEL_W-1:0]  eff_meter;
	logic [QUIET_W-1:0]  eff_quiet;
	logic                acc_en, pos_last, par_last, close;

	logic [DIV_PROD_W-1:0] div_prod;
	logic [ENERGY_W-1:0]   div_quot;
	logic [SQ_REM_W-1:0]   shifted, trial;
	logic                  root_ge;

	logic [SCALE_PROD_W-1:0] scale_prod;
	logic [SCALE_Q_W-1:0]    q5;
	logic [LEVEL_W-1:0]      raw_next, meter_next;
	logic [QUIET_W-1:0]      quiet_next;

	logic slot_free, load_acc, load_emit;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Square of the queue head after a right shift by four.
	assign head_v  = head.ys[SAMPLE_W-1:ENERGY_SHIFT];
	assign head_sq = SQ_W'(head_v) * SQ_W'(head_v);

	// Frame bookkeeping and energy sum, from a cleared state at a new take.
	always_comb begin
		eff_pos    = start_q ? '0 : pos_q;
		eff_stride = start_q ? '0 : stride_q;
		eff_parity = start_q ? '0 : parity_q;
		eff_energy = start_q ? '0 : energy_q;
		eff_meter  = start_q ? '0 : meter_q;
		eff_quiet  = start_q ? '0 : quiet_q;

		acc_en  = (eff_parity == PARITY_LAST) && (eff_stride == '0);
		acc_sum = {1'b0, eff_energy} + (ENERGY_W + 1)'(sq_q);
		if (!acc_en) begin
			acc_val = eff_energy;
		end else if (acc_sum[ENERGY_W]) begin
			acc_val = '1;
		end else begin
			acc_val = acc_sum[ENERGY_W-1:0];
		end

		pos_last = (eff_pos == FRAME_LAST);
		par_last = (eff_parity == PARITY_LAST);
		close    = pos_last && par_last;

		pos_next = pos_last ? '0 : eff_pos + 1'b1;
		if (pos_last || (eff_stride == STRIDE_LAST)) begin
			stride_next = '0;
		end else begin
			stride_next = eff_stride + 1'b1;
		end
		if (!pos_last) begin
			parity_next = eff_parity;
		end else if (par_last) begin
			parity_next = '0;
		end else begin
			parity_next = eff_parity + 1'b1;
		end
	end

	// Division of the energy by the interval count: reciprocal product and shift.
	always_comb begin
		div_prod = DIV_PROD_W'(dq_q) * DIV_PROD_W'(DIV_RECIP_V);
		div_quot = ENERGY_W'(div_prod >> DIV_SHIFT);
	end

	// One digit step of the integer square root.
	always_comb begin
		shifted = {srem_q[SQ_REM_W-3:0], dq_q[ENERGY_W-1 -: 2]};
		trial   = SQ_REM_W'({root_q, 2'b01});
		root_ge = (shifted >= trial);
	end

	// Scale the root by two fifths, cap it, then update meter and quiet count.
	always_comb begin
		scale_prod = SCALE_PROD_W'({root_q, 1'b0}) * SCALE_PROD_W'(DIV5_MUL);
		q5         = scale_prod[SCALE_PROD_W-1:DIV5_SHIFT];
		raw_next   = (q5 > SCALE_Q_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : q5[LEVEL_W-1:0];

		if (raw_q > meter_q) begin
			meter_next = raw_q;
		end else begin
			meter_next = meter_q - ((meter_q - raw_q) >> 1);
		end
		if (raw_q < thresh) begin
			quiet_next = (quiet_q == '1) ? quiet_q : quiet_q + 1'b1;
		end else begin
			quiet_next = '0;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_stat.empty) begin
					state_d = B_ACCUM;
				end
			end
			B_ACCUM: begin
				if (close) begin
					state_d = B_DIVIDE;
				end else if (slot_free) begin
					state_d = q_stat.empty ? B_IDLE : B_ACCUM;
				end else begin
					state_d = B_EMIT;
				end
			end
			B_DIVIDE: begin
				state_d = B_ROOT;
			end
			B_ROOT: begin
				if (step_q == ROOT_STEP_LAST) begin
					state_d = B_SCALE;
				end
			end
			B_SCALE: begin
				state_d = B_METER;
			end
			B_METER: begin
				state_d = B_EMIT;
			end
			B_EMIT: begin
				if (slot_free) begin
					state_d = q_stat.empty ? B_IDLE : B_ACCUM;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// State outputs: queue pop and output register loads.
	always_comb begin
		pop       = 1'b0;
		load_acc  = 1'b0;
		load_emit = 1'b0;
		case (state_q)
			B_IDLE: begin
				pop = !q_stat.empty;
			end
			B_ACCUM: begin
				load_acc = !close && slot_free;
				pop      = !close && slot_free && !q_stat.empty;
			end
			B_EMIT: begin
				load_emit = slot_free;
				pop       = slot_free && !q_stat.empty;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// Control and meter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			stride_q    <= '0;
			parity_q    <= '0;
			energy_q    <= '0;
			meter_q     <= '0;
			quiet_q     <= '0;
			step_q      <= '0;
		end else begin
			state_q <= state_d;

			if (load_acc || load_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				B_ACCUM: begin
					pos_q    <= pos_next;
					stride_q <= stride_next;
					parity_q <= parity_next;
					energy_q <= close ? '0 : acc_val;
					meter_q  <= eff_meter;
					quiet_q  <= eff_quiet;
					step_q   <= '0;
				end
				B_ROOT: begin
					step_q <= step_q + 1'b1;
				end
				B_METER: begin
					meter_q <= meter_next;
					quiet_q <= quiet_next;
				end
				default: begin
					step_q <= step_q;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			ys_q    <= head.ys;
			start_q <= head.start;
			sq_q    <= head_sq;
		end

		case (state_q)
			B_ACCUM: begin
				upd_q  <= close;
				dq_q   <= acc_val;
				srem_q <= '0;
				root_q <= '0;
			end
			B_DIVIDE: begin
				dq_q <= div_quot;
			end
			B_ROOT: begin
				srem_q <= root_ge ? shifted - trial : shifted;
				root_q <= {root_q[ROOT_W-2:0], root_ge};
				dq_q   <= {dq_q[ENERGY_W-3:0], 2'b00};
			end
			B_SCALE: begin
				raw_q <= raw_next;
			end
			default: begin
				raw_q <= raw_q;
			end
		endcase

		if (load_acc) begin
			out_q.filtered_sample <= ys_q;
			out_q.level_update    <= 1'b0;
			out_q.raw_level       <= '0;
			out_q.smoothed_level  <= eff_meter;
			out_q.silence_stop    <= (eff_quiet >= sil_upd);
		end else if (load_emit) begin
			out_q.filtered_sample <= ys_q;
			out_q.level_update    <= upd_q;
			out_q.raw_level       <= upd_q ? raw_q : '0;
			out_q.smoothed_level  <= meter_q;
			out_q.silence_stop    <= (quiet_q >= sil_upd);
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/highpass_level_meter_silence_detect.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Beat contents
// s_axis    in         tdata: sample; tuser: start_of_take
// m_axis    out        tdata: filtered_sample, raw_level, smoothed_level; tuser: flags
// cfg       in         cfg_index selects the register, cfg_data carries its value
//
// In the filter a sample goes through the difference add, then the
// coefficient product with its clamps, which feeds the next sample.
// A sample that closes a meter interval also goes through the meter:
// one reciprocal division, 14 square root steps, scaling, meter update, output.
// A four-beat queue lets the filter run on while the meter works or the output
// stalls. Reset clears control, filter and meter state and sets register defaults.

`include "highpass_level_meter_silence_detect_defines.svh"

module highpass_level_meter_silence_detect import hlm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] sample
	input  logic                   s_axis_tuser,   // start_of_take
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] filtered_sample,
	                                               // [22:16] raw_level,
	                                               // [29:23] smoothed_level, [31:30] zero
	output logic [1:0]             m_axis_tuser,   // [0] level_update, [1] silence_stop
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [COEF_W-1:0]  coef_q;
	logic [LEVEL_W-1:0] thresh_q;
	logic [QUIET_W-1:0] sil_upd_q;

	q_status_t q_stat;
	q_entry_t  q_push_data;
	q_entry_t  q_head;
	logic      q_push;
	logic      q_pop;
	result_t   result;

	// Configuration registers, always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q    <= COEF_RESET;
			thresh_q  <= THRESH_RESET;
			sil_upd_q <= UPDATES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COEF:    coef_q    <= cfg_data[COEF_W-1:0];
				CFG_THRESH:  thresh_q  <= cfg_data[LEVEL_W-1:0];
				CFG_UPDATES: sil_upd_q <= cfg_data[QUIET_W-1:0];
				default:     coef_q    <= coef_q;
			endcase
		end
	end

	// Filter front end.
	hlm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_sample ($signed(s_axis_tdata)),
		.in_start  (s_axis_tuser),
		.coef      (coef_q),
		.q_stat    (q_stat),
		.push      (q_push),
		.push_data (q_push_data)
	);

	// Queue between filter and meter.
	hlm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.head      (q_head),
		.q_stat    (q_stat)
	);

	// Level meter and output register.
	hlm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head      (q_head),
		.pop       (q_pop),
		.thresh    (thresh_q),
		.sil_upd   (sil_upd_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (result)
	);

	assign m_axis_tdata = {{TDATA_PAD{1'b0}}, result.smoothed_level, result.raw_level,
		result.filtered_sample};
	assign m_axis_tuser = {result.silence_stop, result.level_update};

	// Checks on levels, queue and front end pacing.
	`HLM_ASSERT_SAME(a_raw_capped, clk, arst_n, m_axis_tvalid,
		m_axis_tdata[22:16] <= LEVEL_W'(LEVEL_MAX), "raw level above cap")
	`HLM_ASSERT_SAME(a_raw_only_on_update, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0],
		m_axis_tdata[22:16] == '0, "raw level without an update")
	`HLM_ASSERT_SAME(a_queue_no_overflow, clk, arst_n, q_push, !q_stat.full,
		"push into a full queue")
	`HLM_ASSERT_NEXT(a_front_one_in_flight, clk, arst_n, s_axis_tvalid && s_axis_tready,
		!s_axis_tready, "front end took a second sample")

endmodule

`default_nettype wire

FILE: tb/tb_highpass_level_meter_silence_detect.sv
`timescale 1ns / 1ps

module tb_highpass_level_meter_silence_detect;
	import hlm_pkg::*;

	// Limits of the filter state, the sent sample and the energy sum.
	localparam longint Y_HIGH      = (longint'(1) <<< (Y_W - 1)) - 1;
	localparam longint Y_LOW       = -Y_HIGH - 1;
	localparam longint S_HIGH      = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint S_LOW       = -S_HIGH - 1;
	localparam longint ENERGY_FULL = (longint'(1) << ENERGY_W) - 1;

	// Samples in one meter interval.
	localparam int INTERVAL = FRAME_SAMPLES * FRAMES_PER_UPDATE;

	// Index beyond the register list; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam int AMPLITUDES [6] = '{0, 16, 300, 1500, 6000, 32767};

	localparam logic [SAMPLE_W-1:0] CORNER_SAMPLES [16] = '{
		16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF,
		16'h5555, 16'hAAAA, 16'hFFF0, 16'hFFEF, 16'h7FFF, 16'h8000, 16'h000F, 16'h0000
	};
	localparam logic [15:0] CORNER_STARTS = 16'b0001_0000_0000_0001;

	// Filter, meter and silence predictor with the queue of results it expects.
	class highpass_meter_scoreboard;
		logic [COEF_W-1:0]          coef;
		logic [LEVEL_W-1:0]         threshold;
		logic [QUIET_W-1:0]         quiet_needed;
		logic signed [SAMPLE_W-1:0] prev_in;
		logic signed [Y_W-1:0]      prev_out;
		int                         frame_pos;
		int                         frame_count;
		logic [ENERGY_W-1:0]        energy;
		logic [LEVEL_W-1:0]         meter;
		logic [QUIET_W-1:0]         quiet_run;
		result_t                    expected_beats [$];
		int                         mismatches;

		function new();
			coef         = COEF_RESET;
			threshold    = THRESH_RESET;
			quiet_needed = UPDATES_RESET;
			mismatches   = 0;
			clear_take();
		endfunction

		function void clear_take();
			prev_in     = '0;
			prev_out    = '0;
			frame_pos   = 0;
			frame_count = 0;
			energy      = '0;
			meter       = '0;
			quiet_run   = '0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_COEF:    coef = val[COEF_W-1:0];
				CFG_THRESH:  threshold = val[LEVEL_W-1:0];
				CFG_UPDATES: quiet_needed = val[QUIET_W-1:0];
				default: ;
			endcase
		endfunction

		// Floor square root, one result bit at a time from the top.
		function longint square_root(longint n);
			longint root;
			longint trial;
			root = 0;
			for (int b = 15; b >= 0; b--) begin
				trial = root | (longint'(1) << b);
				if (trial * trial <= n)
					root = trial;
			end
			return root;
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] smp, bit take_start);
			longint  x;
			longint  y;
			longint  ys;
			longint  v;
			longint  lvl;
			longint  m;
			result_t want;
			x = longint'(signed'(smp));
			if (take_start)
				clear_take();

			// One-pole high-pass; the arithmetic shift is the floor division by 2^15.
			y = (longint'(coef) * (longint'(prev_out) + x - longint'(prev_in))) >>> FRAC_BITS;
			if (y > Y_HIGH)
				y = Y_HIGH;
			if (y < Y_LOW)
				y = Y_LOW;
			prev_in  = x[SAMPLE_W-1:0];
			prev_out = y[Y_W-1:0];
			ys = (y > S_HIGH) ? S_HIGH : ((y < S_LOW) ? S_LOW : y);

			want.level_update = 1'b0;
			want.raw_level    = '0;

			// Energy of every stride-th sample in the last frame of the interval.
			if (frame_count >= FRAMES_PER_UPDATE - 1 && frame_pos % METER_STRIDE == 0) begin
				v = ys >>> ENERGY_SHIFT;
				if (longint'(energy) + v * v > ENERGY_FULL)
					energy = '1;
				else
					energy = energy + ENERGY_W'(v * v);
			end

			frame_pos++;
			if (frame_pos >= FRAME_SAMPLES) begin
				frame_pos = 0;
				frame_count++;
				if (frame_count >= FRAMES_PER_UPDATE) begin
					frame_count = 0;
					lvl = square_root(longint'(energy) / METER_DIV) * 16 / 40;
					if (lvl > LEVEL_MAX)
						lvl = LEVEL_MAX;
					energy = '0;
					want.level_update = 1'b1;
					want.raw_level    = lvl[LEVEL_W-1:0];

					// Fast attack, half-step release.
					m = meter;
					if (lvl > m)
						m = lvl;
					else
						m = m - (m - lvl) / 2;
					meter = m[LEVEL_W-1:0];

					if (lvl < threshold) begin
						if (quiet_run != '1)
							quiet_run++;
					end else begin
						quiet_run = '0;
					end
				end
			end

			want.filtered_sample = ys[SAMPLE_W-1:0];
			want.smoothed_level  = meter;
			want.silence_stop    = (quiet_run >= quiet_needed);
			expected_beats.push_back(want);
		endfunction

		function void compare_field(string field, logic signed [31:0] want,
			logic signed [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_beats.size() == 0) begin
				$error("output beat with no expectation waiting: sample %0d",
					got.filtered_sample);
				mismatches++;
				return;
			end
			want = expected_beats.pop_front();
			compare_field("filtered_sample", want.filtered_sample, got.filtered_sample);
			compare_field("level_update", want.level_update, got.level_update);
			compare_field("raw_level", want.raw_level, got.raw_level);
			compare_field("smoothed_level", want.smoothed_level, got.smoothed_level);
			compare_field("silence_stop", want.silence_stop, got.silence_stop);
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [SAMPLE_W-1:0]    s_axis_tdata = '0;   // [15:0] sample
	logic                   s_axis_tuser = 1'b0; // start_of_take
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [15:0] filtered_sample, [22:16] raw_level,
	                                             // [29:23] smoothed_level
	logic [1:0]             m_axis_tuser;        // [0] level_update, [1] silence_stop
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	highpass_meter_scoreboard sb = new();

	int sender_idle_pct = 0;
	int stall_pct       = 0;
	int hold_cycles     = 0;

	highpass_level_meter_silence_detect u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: check each accepted beat, then choose the next ready.
	// A requested hold-off keeps ready low for a counted number of cycles.
	initial forever begin
		result_t got;
		@(posedge clk);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.filtered_sample = m_axis_tdata[15:0];
			got.raw_level       = m_axis_tdata[22:16];
			got.smoothed_level  = m_axis_tdata[29:23];
			got.level_update    = m_axis_tuser[0];
			got.silence_stop    = m_axis_tuser[1];
			sb.check_result(got);
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one sample after a random gap and wait for its beat to be taken.
	task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit take_start);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		s_axis_tuser  <= take_start;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_sample(smp, take_start);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_register(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int coefficient, input int thresh, input int updates);
		write_register(CFG_COEF, CFG_DATA_W'(coefficient));
		write_register(CFG_THRESH, CFG_DATA_W'(thresh));
		write_register(CFG_UPDATES, CFG_DATA_W'(updates));
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// A take: a start beat, then noise whose amplitude is redrawn at each meter
	// interval (and now and then inside one), with optional stray starts.
	task automatic send_take(input int n_samples, input int amp_cap, input int stray_per_mille,
		input int hold_at);
		int                  amp;
		logic [SAMPLE_W-1:0] smp;
		bit                  take_start;
		amp = 0;
		for (int i = 0; i < n_samples; i++) begin
			if (i % INTERVAL == 0 || $urandom_range(299) == 0) begin
				amp = AMPLITUDES[$urandom_range(5)];
				if (amp > amp_cap)
					amp = amp_cap;
			end
			if (amp >= 32767)
				smp = SAMPLE_W'($urandom());
			else
				smp = SAMPLE_W'(int'($urandom_range(2 * amp)) - amp);
			take_start = (i == 0) || ($urandom_range(999) < stray_per_mille);
			if (i == hold_at)
				hold_cycles = 400;
			send_sample(smp, take_start);
		end
	endtask

	initial begin
		#20_000_000;
		$display("** highpass_level_meter_silence_detect: FAILED **");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner samples under the reset settings, with a start inside the take.
		for (int i = 0; i < 16; i++)
			send_sample(CORNER_SAMPLES[i], CORNER_STARTS[i]);
		wait_drain();

		// No idling, highest coefficient: one full meter interval, a write beyond
		// the register list, and a long receiver hold-off so the input backs up.
		configure(32767, 100, 1);
		write_register(CFG_UNUSED, 16'hFFFF);
		send_take(INTERVAL + 10, 32767, 0, 200);
		wait_drain();

		// Sender idling; a quiet-update count of zero keeps the stop flag up.
		sender_idle_pct = 63;
		configure(1, 10, 0);
		send_take(60, 32767, 20, -1);
		wait_drain();

		// Receiver stalling.
		sender_idle_pct = 0;
		stall_pct       = 63;
		configure(20000, 40, 2);
		send_take(60, 32767, 0, -1);
		wait_drain();

		// Both sides idling, zero coefficient and threshold, frequent stray starts.
		sender_idle_pct = 13;
		stall_pct       = 13;
		configure(0, 0, 1);
		send_take(60, 32767, 50, -1);
		wait_drain();

		repeat (64) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected beats never arrived", sb.pending());
			sb.mismatches++;
		end
		if (sb.mismatches == 0)
			$display("** highpass_level_meter_silence_detect: PASSED **");
		else
			$display("** highpass_level_meter_silence_detect: FAILED **");
		$finish;
	end

endmodule
